/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorted list block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property violated");

// Expression must never be true at a clock edge outside reset.
`define AST_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition seen");

`endif

/* rtl/sli_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted list package
// Types and codes shared by the sorted list controller, datapath and top.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int KEY_W    = 32;
   localparam int POS_W    = 5;
   localparam int CNT_W    = 6;
   localparam int STATUS_W = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } sli_cmd_type;

endpackage

/* rtl/sorted_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// Sorted list with insert and remove
// Keeps up to CAPACITY signed keys in ascending order.
//
// req channel: req_mode selects insert (0) or remove (1) of req_value. A
// transfer happens when req_valid is high and req_stall is low.
// rsp channel: one result per request with status, position, count and the
// empty and full flags as they stand after the request.
// Each request is captured in the accept cycle, which compares the key against
// every held entry in parallel; in the update state the entry cells shift in
// place and the result register loads once it is free. A new request is
// taken only after the previous one commits, so requests never overlap.
// rsp_valid is registered and rises after the commit. While a result is
// stalled the next request is still accepted and compared; its commit waits
// until the result register is free.
// Reset empties the list and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_list_insert_remove
   import sli_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic signed [KEY_W-1:0]    req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic        [POS_W-1:0]    rsp_position,
   output logic        [CNT_W-1:0]    rsp_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);

   sli_cmd_type cmd;

   sli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sli_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full)
   );

   `AST_NEVER(a_commit_over_stall, clock, reset, cmd.commit && rsp_valid && rsp_stall)
   `AST_NEVER(a_capture_commit, clock, reset, cmd.capture && cmd.commit)
   `AST_HOLDS(a_capture_blocks, clock, reset, cmd.capture |=> req_stall)
   `AST_NEVER(a_empty_and_full, clock, reset, rsp_valid && rsp_is_empty && rsp_is_full)
   `AST_NEVER(a_fail_position, clock, reset, rsp_valid && rsp_status != STATUS_DONE && |rsp_position)

endmodule

/* rtl/sli_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted list controller
// Sequences capture and commit of one request and owns the result valid.
// ----------------------------------------------------------------------------
module sli_ctrl
   import sli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sli_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_UPDATE: begin
            cmd.commit = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/sli_dp.sv */
// ----------------------------------------------------------------------------
// Sorted list datapath
// Entry cells with parallel compare, in-place shift and the result register.
// ----------------------------------------------------------------------------
module sli_dp
   import sli_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  sli_cmd_type                cmd,
   input  logic                       req_mode,
   input  logic signed [KEY_W-1:0]    req_value,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic        [POS_W-1:0]    rsp_position,
   output logic        [CNT_W-1:0]    rsp_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic signed [KEY_W-1:0] entry_ff [CAPACITY];
   logic signed [KEY_W-1:0] entry_in [CAPACITY];
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic [CAPACITY-1:0]     lt_ff;
   logic [CAPACITY-1:0]     lt_in;
   logic [CAPACITY-1:0]     eq_ff;
   logic [CAPACITY-1:0]     eq_in;
   logic signed [KEY_W-1:0] key_ff;
   logic                    mode_ff;

   logic [CAPACITY-1:0]     first;
   logic [IW-1:0]           pos;
   logic                    found;
   logic                    full;
   logic                    do_ins;
   logic                    do_rem;
   status_type              status;

   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [POS_W-1:0]        rsp_position_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic                    rsp_is_empty_ff;
   logic                    rsp_is_full_ff;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_in[i] = (count_ff > CW'(i)) && (entry_ff[i] < req_value);
         eq_in[i] = (count_ff > CW'(i)) && (entry_ff[i] == req_value);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lt_ff   <= lt_in;
         eq_ff   <= eq_in;
         key_ff  <= req_value;
         mode_ff <= req_mode;
      end
   end

   assign first[0] = !lt_ff[0];
   for (genvar j = 1; j < CAPACITY; j++) begin : g_first
      assign first[j] = !lt_ff[j] && lt_ff[j-1];
   end

   always_comb begin
      pos = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         pos = pos | (first[j] ? IW'(j) : IW'(0));
      end
   end

   assign found  = |(first & eq_ff);
   assign full   = (count_ff == CW'(CAPACITY));
   assign do_ins = (mode_ff == MODE_INSERT) && !full;
   assign do_rem = (mode_ff == MODE_REMOVE) && found;

   always_comb begin
      if (mode_ff == MODE_INSERT) begin
         status = full ? STATUS_FULL : STATUS_DONE;
      end else begin
         status = found ? STATUS_DONE : STATUS_NOT_FOUND;
      end
   end

   always_comb begin
      if (do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (do_rem) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      always_comb begin
         entry_in[j] = entry_ff[j];
         if (do_ins && !lt_ff[j]) begin
            if (first[j]) begin
               entry_in[j] = key_ff;
            end else begin
               entry_in[j] = entry_ff[(j > 0) ? j - 1 : 0];
            end
         end else if (do_rem && !lt_ff[j] && (j < CAPACITY - 1)) begin
            entry_in[j] = entry_ff[(j < CAPACITY - 1) ? j + 1 : j];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.commit) begin
            entry_ff[j] <= entry_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff   <= status;
         rsp_position_ff <= (do_ins || do_rem) ? POS_W'(pos) : '0;
         rsp_count_ff    <= CNT_W'(count_in);
         rsp_is_empty_ff <= (count_in == '0);
         rsp_is_full_ff  <= (count_in == CW'(CAPACITY));
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;

endmodule

/* tb/sv/sorted_list_insert_remove_tb.sv */
// ----------------------------------------------------------------------------
// Sorted list insert/remove testbench
// Drives insert and remove requests with random gaps and result stalls. Each
// transfer is run through a local ordered-list predictor, and every result is
// compared field by field with the oldest expectation. A short directed
// sequence covers the key extremes, duplicates, a missing key and removal
// down to empty. Random phases then fill the list past capacity, drain it
// and mix both request kinds, with removes mostly on keys the list holds.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_tb;
   import sli_pkg::*;

   localparam int LIST_DEPTH     = 32;
   localparam int TOTAL_ITEMS    = 1900;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int MISMATCH_SHOWN = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int POOL_SIZE      = 12;

   typedef logic signed [KEY_W-1:0] key_t;

   typedef struct {
      logic mode;
      key_t value;
      bit   drain_first;
      int   idle_max;
   } request_t;

   typedef struct {
      status_type        status;
      logic [POS_W-1:0]  position;
      logic [CNT_W-1:0]  count;
      logic              is_empty;
      logic              is_full;
   } list_result_t;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   logic                req_mode     = MODE_INSERT;
   key_t                req_value    = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [POS_W-1:0]    rsp_position;
   logic [CNT_W-1:0]    rsp_count;
   logic                rsp_is_empty;
   logic                rsp_is_full;

   request_t     pending_requests[$];
   list_result_t expected_results[$];
   key_t         model_keys[$];
   key_t         plan_keys[$];
   key_t         key_pool[POOL_SIZE];

   request_t     req_next;
   list_result_t rsp_expected;
   int           reset_left     = RESET_CYCLES;
   int           req_issued     = 0;
   int           req_xfer_total = 0;
   int           rsp_xfer_total = 0;
   int           rsp_seen       = 0;
   int           req_gap_left   = 0;
   int           rsp_hold_left  = 0;
   int           idle_max       = 0;
   int           mismatch_count = 0;
   int           cycle_count    = 0;

   sorted_list_insert_remove dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic list_result_t sorted_apply(ref key_t keys[$], input logic mode,
                                                 input key_t value);
      list_result_t r;
      int           idx;
      r.status   = STATUS_DONE;
      r.position = '0;
      idx        = 0;
      if (mode == MODE_INSERT) begin
         if (keys.size() >= LIST_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            while (idx < keys.size() && keys[idx] < value) idx++;
            keys.insert(idx, value);
            r.position = idx[POS_W-1:0];
         end
      end else begin
         while (idx < keys.size() && keys[idx] != value) idx++;
         if (idx >= keys.size()) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            keys.delete(idx);
            r.position = idx[POS_W-1:0];
         end
      end
      r.count    = CNT_W'(keys.size());
      r.is_empty = (keys.size() == 0);
      r.is_full  = (keys.size() >= LIST_DEPTH);
      return r;
   endfunction

   function automatic bit results_outstanding();
      return expected_results.size() != 0 || req_xfer_total != req_issued;
   endfunction

   function automatic key_t pick_key(input logic mode);
      int sel;
      sel = $urandom_range(0, 9);
      if (plan_keys.size() > 0 && ((mode == MODE_REMOVE && sel < 7) || sel < 2))
         return plan_keys[$urandom_range(0, plan_keys.size() - 1)];
      if (sel < 6)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return key_t'($urandom);
   endfunction

   task automatic add_request(input logic mode, input key_t value, input bit drain_first,
                              input int idle);
      request_t item;
      item.mode        = mode;
      item.value       = value;
      item.drain_first = drain_first;
      item.idle_max    = idle;
      pending_requests.push_back(item);
      void'(sorted_apply(plan_keys, mode, value));
   endtask

   task automatic check_field(input string field, input logic [KEY_W-1:0] expected,
                              input logic [KEY_W-1:0] actual);
      if (expected !== actual) begin
         mismatch_count++;
         if (mismatch_count <= MISMATCH_SHOWN)
            $display("%s mismatch on result %0d: expected %0d, got %0d",
                     field, rsp_xfer_total, expected, actual);
      end
   endtask

   // drive requests and result stalls
   always @(negedge clock) begin
      if (reset_left > 0) begin
         reset_left--;
         if (reset_left == 0) reset <= 1'b0;
      end else begin
         if (rsp_xfer_total != rsp_seen) begin
            rsp_seen      = rsp_xfer_total;
            rsp_hold_left = $urandom_range(0, idle_max);
         end
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end

         if (!(req_valid && req_xfer_total != req_issued)) begin
            if (req_gap_left > 0) begin
               req_valid <= 1'b0;
               req_gap_left--;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first && results_outstanding())) begin
               req_next = pending_requests.pop_front();
               req_valid    <= 1'b1;
               req_mode     <= req_next.mode;
               req_value    <= req_next.value;
               req_issued++;
               idle_max     = req_next.idle_max;
               req_gap_left = $urandom_range(0, idle_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // check results, then predict accepted requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_xfer_total++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN)
                  $display("result %0d arrived with nothing expected", rsp_xfer_total);
            end else begin
               rsp_expected = expected_results.pop_front();
               check_field("status", rsp_expected.status, rsp_status);
               check_field("position", rsp_expected.position, rsp_position);
               check_field("count", rsp_expected.count, rsp_count);
               check_field("is_empty", rsp_expected.is_empty, rsp_is_empty);
               check_field("is_full", rsp_expected.is_full, rsp_is_full);
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(sorted_apply(model_keys, req_mode, req_value));
            req_xfer_total++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[sorted_list_insert_remove] ERROR");
         $finish;
      end
   end

   initial begin
      int   phase_kind;
      int   phase_len;
      int   phase_idle;
      int   insert_pct;
      bit   phase_drain;
      bit   first_phase;
      logic mode;

      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7FFF_FFFF;
      key_pool[2] = 32'sh0000_0000;
      key_pool[3] = -32'sd1;
      key_pool[4] = 32'sh5555_5555;
      key_pool[5] = 32'shAAAA_AAAA;
      for (int p = 6; p < POOL_SIZE; p++) key_pool[p] = key_t'($urandom);

      // remove on empty, extremes, duplicate ahead of equal, missing key, drain
      add_request(MODE_REMOVE, 32'sd5, 1'b0, 4);
      add_request(MODE_INSERT, 32'sh7FFF_FFFF, 1'b0, 4);
      add_request(MODE_INSERT, 32'sh8000_0000, 1'b0, 4);
      add_request(MODE_INSERT, 32'sh0000_0000, 1'b0, 4);
      add_request(MODE_INSERT, -32'sd1, 1'b0, 4);
      add_request(MODE_INSERT, 32'sh0000_0000, 1'b0, 4);
      add_request(MODE_INSERT, 32'sh5555_5555, 1'b0, 0);
      add_request(MODE_INSERT, 32'shAAAA_AAAA, 1'b0, 0);
      add_request(MODE_REMOVE, 32'sh0000_0000, 1'b0, 0);
      add_request(MODE_REMOVE, 32'sd1, 1'b0, 0);
      add_request(MODE_REMOVE, 32'sh7FFF_FFFF, 1'b0, 8);
      add_request(MODE_REMOVE, 32'sh8000_0000, 1'b0, 8);
      add_request(MODE_REMOVE, 32'shAAAA_AAAA, 1'b0, 8);
      add_request(MODE_REMOVE, 32'sh5555_5555, 1'b0, 8);
      add_request(MODE_REMOVE, -32'sd1, 1'b0, 8);
      add_request(MODE_REMOVE, 32'sh0000_0000, 1'b0, 8);
      add_request(MODE_REMOVE, 32'sh0000_0000, 1'b0, 8);

      first_phase = 1'b1;
      while (pending_requests.size() < TOTAL_ITEMS) begin
         phase_kind  = first_phase ? 3 : $urandom_range(0, 3);
         phase_len   = (phase_kind == 3) ? $urandom_range(40, 64) : $urandom_range(16, 72);
         phase_idle  = ($urandom_range(0, 3) == 0) ? 0 : 8;
         phase_drain = first_phase || ($urandom_range(0, 2) == 0);
         first_phase = 1'b0;
         case (phase_kind)
            0: insert_pct = 85;
            1: insert_pct = 10;
            2: insert_pct = 50;
            default: insert_pct = 100;
         endcase
         for (int k = 0; k < phase_len; k++) begin
            mode = ($urandom_range(1, 100) <= insert_pct) ? MODE_INSERT : MODE_REMOVE;
            add_request(mode, pick_key(mode), phase_drain && k == 0, phase_idle);
         end
      end

      while (reset || pending_requests.size() != 0 || results_outstanding())
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[sorted_list_insert_remove] OK");
      end else begin
         $display("[sorted_list_insert_remove] ERROR");
      end
      $finish;
   end

endmodule
